// File: rtl/button_debounce_press_classifier_unit_defines.svh
// Assertion macros shared by the button classifier RTL.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BDPC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDPC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/bdpc_pkg.sv
// Shared types and constants for the button debounce and press classifier.
package bdpc_pkg;

   localparam int TIME_W    = 32;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 8;

   // Register indexes on the configuration channel
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS = 8'd1;

   // Register reset values
   localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
   localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd2000;

   // Pin levels (active-low button)
   localparam logic LEVEL_RELEASED = 1'b1;
   localparam logic LEVEL_PRESSED  = 1'b0;

   // One input sample
   typedef struct packed {
      logic              raw_level;
      logic [TIME_W-1:0] now_ms;
      logic              display_awake;
      logic              config_mode;
      logic              charging_active;
   } req_type;

   // One classification result
   typedef struct packed {
      logic stable_level;
      logic short_press;
      logic long_press;
      logic wake_display;
      logic reset_timeout;
      logic switch_page;
      logic toggle_config;
   } rsp_type;

endpackage

// File: rtl/bdpc_ifs.sv
// Channel interfaces: sample input, result output and register writes.
interface bdpc_req_if;
   logic                            valid;
   logic                            ready;
   logic                            raw_level;
   logic [bdpc_pkg::TIME_W-1:0]     now_ms;
   logic                            display_awake;
   logic                            config_mode;
   logic                            charging_active;

   modport source (output valid, raw_level, now_ms, display_awake, config_mode,
                   charging_active, input ready);
   modport sink   (input valid, raw_level, now_ms, display_awake, config_mode,
                   charging_active, output ready);
endinterface

interface bdpc_rsp_if;
   logic valid;
   logic ready;
   logic stable_level;
   logic short_press;
   logic long_press;
   logic wake_display;
   logic reset_timeout;
   logic switch_page;
   logic toggle_config;

   modport source (output valid, stable_level, short_press, long_press, wake_display,
                   reset_timeout, switch_page, toggle_config, input ready);
   modport sink   (input valid, stable_level, short_press, long_press, wake_display,
                   reset_timeout, switch_page, toggle_config, output ready);
endinterface

interface bdpc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [bdpc_pkg::CSR_IDX_W-1:0]     index;
   logic [bdpc_pkg::CFG_W-1:0]         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/button_debounce_press_classifier_unit.sv
// Top level: debounces an active-low button and classifies short and long presses.
//
// Channels:
//   req_ch  samples: pin level, 32-bit ms timestamp, display/config/charging flags.
//   rsp_ch  one result per sample: debounced level and press/request flags.
//   csr_ch  register writes: index 0 debounce_ms, index 1 long_press_ms;
//           always ready, other indexes are ignored. Write only while idle.
// Timing:
//   A sample is taken into the input register; the classifier then updates
//   its state and loads the result register, which drives rsp valid and the
//   rsp beat. One sample per cycle is sustained while rsp is ready; the only
//   loop is the state update feeding the next sample.
// Stall:
//   While rsp is held (valid, not ready) the result and the input register
//   hold; req_ready drops once the input register is also occupied.
// Reset:
//   Synchronous, active high. Pipeline is emptied, registers return to
//   debounce_ms 50 and long_press_ms 2000, button state to released.
`include "button_debounce_press_classifier_unit_defines.svh"

module button_debounce_press_classifier_unit (
   input logic       clock,
   input logic       reset,
   bdpc_req_if.sink   req_ch,
   bdpc_rsp_if.source rsp_ch,
   bdpc_csr_if.sink   csr_ch
);

   // configuration registers
   logic [bdpc_pkg::CFG_W-1:0]  debounce_ms_ff;
   logic [bdpc_pkg::CFG_W-1:0]  long_press_ms_ff;

   // button state
   logic                        last_raw_ff,  last_raw_in;
   logic                        debounced_ff, debounced_in;
   logic [bdpc_pkg::TIME_W-1:0] last_change_ff, last_change_in;
   logic [bdpc_pkg::TIME_W-1:0] press_start_ff, press_start_in;
   logic                        long_done_ff, long_done_in;

   // input stage and result stage
   logic                        s1_valid_ff;
   bdpc_pkg::req_type           s1_data_ff;
   logic                        out_valid_ff;
   bdpc_pkg::rsp_type           out_data_ff, out_data_in;

   logic                        out_load;
   logic                        s1_load;

   // pipeline flow
   assign out_load      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !s1_valid_ff || out_load;
   assign s1_load       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready  = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff   <= bdpc_pkg::DEBOUNCE_RST;
         long_press_ms_ff <= bdpc_pkg::LONG_PRESS_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            bdpc_pkg::CSR_DEBOUNCE:   debounce_ms_ff   <= csr_ch.data;
            bdpc_pkg::CSR_LONG_PRESS: long_press_ms_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff.raw_level       <= req_ch.raw_level;
         s1_data_ff.now_ms          <= req_ch.now_ms;
         s1_data_ff.display_awake   <= req_ch.display_awake;
         s1_data_ff.config_mode     <= req_ch.config_mode;
         s1_data_ff.charging_active <= req_ch.charging_active;
      end
   end

   // classifier: next state and result for the sample in the input register
   always_comb begin
      logic                        lvl;
      logic                        changed;
      logic                        stable;
      logic                        accept;
      logic                        new_press;
      logic [bdpc_pkg::TIME_W-1:0] since_change;
      logic [bdpc_pkg::TIME_W-1:0] held;
      logic                        ld_mid;
      logic                        fire;

      lvl          = s1_data_ff.raw_level;
      changed      = (lvl != last_raw_ff);
      // a fresh change leaves zero elapsed time, which is never beyond the window
      since_change = changed ? '0 : (s1_data_ff.now_ms - last_change_ff);
      stable       = (since_change > {{(bdpc_pkg::TIME_W-bdpc_pkg::CFG_W){1'b0}},
                                      debounce_ms_ff});
      accept       = stable && (lvl != debounced_ff);
      new_press    = accept && (lvl == bdpc_pkg::LEVEL_PRESSED);

      last_raw_in    = lvl;
      last_change_in = changed ? s1_data_ff.now_ms : last_change_ff;
      debounced_in   = accept ? lvl : debounced_ff;
      press_start_in = new_press ? s1_data_ff.now_ms : press_start_ff;
      ld_mid         = new_press ? 1'b0 : long_done_ff;

      out_data_in               = '0;
      out_data_in.stable_level  = debounced_in;

      // release without a long press: short press
      if (accept && (lvl == bdpc_pkg::LEVEL_RELEASED) && !long_done_ff &&
          !s1_data_ff.charging_active) begin
         out_data_in.short_press = 1'b1;
         if (!s1_data_ff.display_awake) begin
            out_data_in.wake_display = 1'b1;
         end else if (!s1_data_ff.config_mode) begin
            out_data_in.reset_timeout = 1'b1;
            out_data_in.switch_page   = 1'b1;
         end
      end

      // hold time measured from press start; zero when the press starts now
      held = new_press ? '0 : (s1_data_ff.now_ms - press_start_ff);
      fire = stable && (debounced_in == bdpc_pkg::LEVEL_PRESSED) && !ld_mid &&
             (held >= {{(bdpc_pkg::TIME_W-bdpc_pkg::CFG_W){1'b0}}, long_press_ms_ff});

      long_done_in = fire ? 1'b1 : ld_mid;
      if (fire && !s1_data_ff.charging_active) begin
         out_data_in.long_press    = 1'b1;
         out_data_in.toggle_config = 1'b1;
         if (!s1_data_ff.display_awake) begin
            out_data_in.wake_display = 1'b1;
         end
      end
   end

   // state update, one sample per result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= bdpc_pkg::LEVEL_RELEASED;
         debounced_ff   <= bdpc_pkg::LEVEL_RELEASED;
         last_change_ff <= '0;
         press_start_ff <= '0;
         long_done_ff   <= 1'b0;
      end else if (out_load) begin
         last_raw_ff    <= last_raw_in;
         debounced_ff   <= debounced_in;
         last_change_ff <= last_change_in;
         press_start_ff <= press_start_in;
         long_done_ff   <= long_done_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ch.ready) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.stable_level  = out_data_ff.stable_level;
   assign rsp_ch.short_press   = out_data_ff.short_press;
   assign rsp_ch.long_press    = out_data_ff.long_press;
   assign rsp_ch.wake_display  = out_data_ff.wake_display;
   assign rsp_ch.reset_timeout = out_data_ff.reset_timeout;
   assign rsp_ch.switch_page   = out_data_ff.switch_page;
   assign rsp_ch.toggle_config = out_data_ff.toggle_config;

   // checks
   `BDPC_ASSERT_IMP(a_press_kinds_exclusive, clock, reset, out_valid_ff,
                    !(out_data_ff.short_press && out_data_ff.long_press),
                    "short and long press in one beat")
   `BDPC_ASSERT_IMP(a_toggle_needs_long, clock, reset,
                    out_valid_ff && out_data_ff.toggle_config, out_data_ff.long_press,
                    "config toggle without long press")
   `BDPC_ASSERT_IMP(a_page_needs_short, clock, reset,
                    out_valid_ff && out_data_ff.switch_page,
                    out_data_ff.short_press && out_data_ff.reset_timeout,
                    "page switch without short press")
   `BDPC_ASSERT_IMP(a_level_tracks_state, clock, reset, out_valid_ff,
                    (out_data_ff.stable_level == debounced_ff) &&
                    (!out_data_ff.long_press || long_done_ff),
                    "result disagrees with button state")
   `BDPC_ASSERT_NXT(a_stage_holds, clock, reset,
                    s1_valid_ff && out_valid_ff && !rsp_ch.ready,
                    s1_valid_ff && out_valid_ff,
                    "pipeline dropped a sample under stall")

endmodule

// File: dv/tb.sv
// Self-checking testbench for the button debounce and press classifier.
`timescale 1ns / 100ps

module tb;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any beat
   localparam int MAX_WAIT       = 11;    // longest per-beat gap or stall
   // not decoded by the block
   localparam logic [bdpc_pkg::CSR_IDX_W-1:0] CSR_SPARE = 8'hA5;

   logic clock = 1'b0;
   logic reset;

   bdpc_req_if req_ch();
   bdpc_rsp_if rsp_ch();
   bdpc_csr_if csr_ch();

   button_debounce_press_classifier_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Tracks button state and register values; holds the actions each sample
   // should produce, oldest first.
   class button_scoreboard;
      logic [bdpc_pkg::CFG_W-1:0]  debounce_ms_q;
      logic [bdpc_pkg::CFG_W-1:0]  long_press_ms_q;
      logic                        last_raw;
      logic                        stable;
      logic                        long_handled;
      logic [bdpc_pkg::TIME_W-1:0] last_edge_ms;
      logic [bdpc_pkg::TIME_W-1:0] press_start_ms;
      bdpc_pkg::rsp_type           expected_actions[$];
      int                          mismatches;
      int                          samples;
      int                          results;
      int                          shorts;
      int                          longs;

      function new();
         debounce_ms_q   = bdpc_pkg::DEBOUNCE_RST;
         long_press_ms_q = bdpc_pkg::LONG_PRESS_RST;
         last_raw        = bdpc_pkg::LEVEL_RELEASED;
         stable          = bdpc_pkg::LEVEL_RELEASED;
         long_handled    = 1'b0;
         last_edge_ms    = '0;
         press_start_ms  = '0;
         mismatches      = 0;
         samples         = 0;
         results         = 0;
         shorts          = 0;
         longs           = 0;
      endfunction

      function void write_register(logic [bdpc_pkg::CSR_IDX_W-1:0] index,
                                   logic [bdpc_pkg::CFG_W-1:0] data);
         if (index == bdpc_pkg::CSR_DEBOUNCE)
            debounce_ms_q = data;
         else if (index == bdpc_pkg::CSR_LONG_PRESS)
            long_press_ms_q = data;
      endfunction

      // Debounce one sample and classify the press it completes, if any
      function void note_sample(bdpc_pkg::req_type s);
         bdpc_pkg::rsp_type           act;
         logic [bdpc_pkg::TIME_W-1:0] settled;
         logic [bdpc_pkg::TIME_W-1:0] held;
         act = '0;
         if (s.raw_level != last_raw)
            last_edge_ms = s.now_ms;
         settled = s.now_ms - last_edge_ms;
         if (settled > {16'b0, debounce_ms_q}) begin
            if (s.raw_level != stable) begin
               stable = s.raw_level;
               if (stable == bdpc_pkg::LEVEL_PRESSED) begin
                  press_start_ms = s.now_ms;
                  long_handled   = 1'b0;
               end else if (!long_handled && !s.charging_active) begin
                  // release before long press: short press
                  act.short_press = 1'b1;
                  if (!s.display_awake) begin
                     act.wake_display = 1'b1;
                  end else if (!s.config_mode) begin
                     act.reset_timeout = 1'b1;
                     act.switch_page   = 1'b1;
                  end
               end
            end
            held = s.now_ms - press_start_ms;
            if (stable == bdpc_pkg::LEVEL_PRESSED && !long_handled &&
                held >= {16'b0, long_press_ms_q}) begin
               // fires once per press; charging only mutes the actions
               long_handled = 1'b1;
               if (!s.charging_active) begin
                  act.long_press    = 1'b1;
                  act.wake_display  = !s.display_awake;
                  act.toggle_config = 1'b1;
               end
            end
         end
         last_raw         = s.raw_level;
         act.stable_level = stable;
         expected_actions.push_back(act);
         samples++;
         shorts += int'(act.short_press);
         longs  += int'(act.long_press);
      endfunction

      function void compare_field(string field, logic want, logic got);
         if (got !== want) begin
            $error("%s: expected %b, got %b", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(bdpc_pkg::rsp_type got);
         bdpc_pkg::rsp_type want;
         if (expected_actions.size() == 0) begin
            $error("result beat with no sample pending: %b", got);
            mismatches++;
            return;
         end
         want = expected_actions.pop_front();
         results++;
         compare_field("stable_level",  want.stable_level,  got.stable_level);
         compare_field("short_press",   want.short_press,   got.short_press);
         compare_field("long_press",    want.long_press,    got.long_press);
         compare_field("wake_display",  want.wake_display,  got.wake_display);
         compare_field("reset_timeout", want.reset_timeout, got.reset_timeout);
         compare_field("switch_page",   want.switch_page,   got.switch_page);
         compare_field("toggle_config", want.toggle_config, got.toggle_config);
      endfunction
   endclass

   button_scoreboard            sb;
   logic [bdpc_pkg::TIME_W-1:0] sample_ms;
   bit                          req_burst;
   bit                          rsp_burst;
   int                          idle_cycles = 0;
   int                          settings;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Result side: random stalls, with runs of back-to-back acceptance
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      rsp_burst    = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0)
            rsp_burst = ~rsp_burst;
         stall = rsp_burst ? 0 : int'($urandom_range(0, MAX_WAIT));
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // Beat monitor and watchdog
   always @(posedge clock) begin
      bdpc_pkg::rsp_type seen;
      bdpc_pkg::req_type taken;
      bit                any_beat;
      if (!reset) begin
         any_beat = 1'b0;
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.stable_level  = rsp_ch.stable_level;
            seen.short_press   = rsp_ch.short_press;
            seen.long_press    = rsp_ch.long_press;
            seen.wake_display  = rsp_ch.wake_display;
            seen.reset_timeout = rsp_ch.reset_timeout;
            seen.switch_page   = rsp_ch.switch_page;
            seen.toggle_config = rsp_ch.toggle_config;
            sb.check_result(seen);
            any_beat = 1'b1;
         end
         if (req_ch.valid && req_ch.ready) begin
            taken.raw_level       = req_ch.raw_level;
            taken.now_ms          = req_ch.now_ms;
            taken.display_awake   = req_ch.display_awake;
            taken.config_mode     = req_ch.config_mode;
            taken.charging_active = req_ch.charging_active;
            sb.note_sample(taken);
            any_beat = 1'b1;
         end
         if (csr_ch.valid && csr_ch.ready)
            any_beat = 1'b1;
         if (any_beat)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // One sample beat; entered and left at a falling edge
   task automatic drive_sample(logic level, logic [bdpc_pkg::TIME_W-1:0] ms, logic awake,
                               logic cfg, logic charging);
      int gap;
      gap = req_burst ? 0 : int'($urandom_range(0, MAX_WAIT));
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.raw_level       <= level;
      req_ch.now_ms          <= ms;
      req_ch.display_awake   <= awake;
      req_ch.config_mode     <= cfg;
      req_ch.charging_active <= charging;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Advance the timestamp and send a sample with random flags
   task automatic step_sample(logic level, int unsigned step);
      sample_ms += step;
      drive_sample(level, sample_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 4) == 0);
   endtask

   // Press and release at the reset debounce time; flags held on all four beats
   task automatic directed_tap(logic [bdpc_pkg::TIME_W-1:0] base, logic awake, logic cfg,
                               logic charging);
      drive_sample(bdpc_pkg::LEVEL_PRESSED,  base, awake, cfg, charging);
      drive_sample(bdpc_pkg::LEVEL_PRESSED,  base + bdpc_pkg::DEBOUNCE_RST + 1,
                   awake, cfg, charging);
      drive_sample(bdpc_pkg::LEVEL_RELEASED, base + 100, awake, cfg, charging);
      drive_sample(bdpc_pkg::LEVEL_RELEASED, base + 100 + bdpc_pkg::DEBOUNCE_RST + 1,
                   awake, cfg, charging);
   endtask

   // Register write beat; the caller drops valid after the last one
   task automatic program_csr(logic [bdpc_pkg::CSR_IDX_W-1:0] index,
                              logic [bdpc_pkg::CFG_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_register(index, data);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.expected_actions.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_timing(logic [bdpc_pkg::CFG_W-1:0] debounce,
                             logic [bdpc_pkg::CFG_W-1:0] long_ms);
      wait_drained();
      program_csr(bdpc_pkg::CSR_DEBOUNCE, debounce);
      program_csr(bdpc_pkg::CSR_LONG_PRESS, long_ms);
      csr_ch.valid <= 1'b0;
      settings++;
   endtask

   // Contact chatter shorter than the debounce window
   task automatic bounce(logic level, int unsigned db);
      int n;
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++)
         step_sample((i % 2 == 0) ? level : ~level, $urandom_range(0, db));
   endtask

   // Mostly real presses of random length; some glitches and plain noise
   task automatic press_episode();
      int unsigned db;
      int unsigned lp;
      int unsigned kind;
      int unsigned hold;
      int unsigned n;
      db = 32'(sb.debounce_ms_q);
      lp = 32'(sb.long_press_ms_q);
      if ($urandom_range(0, 7) == 0)
         req_burst = ~req_burst;
      if ($urandom_range(0, 24) == 0)
         sample_ms = $urandom;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++)
            step_sample(1'($urandom_range(0, 1)),
                        ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2*db + 2));
      end else if (kind == 1) begin
         step_sample(bdpc_pkg::LEVEL_PRESSED, $urandom_range(0, db + 2));
         step_sample(bdpc_pkg::LEVEL_RELEASED, $urandom_range(0, db));
      end else begin
         bounce(bdpc_pkg::LEVEL_PRESSED, db);
         step_sample(bdpc_pkg::LEVEL_PRESSED, $urandom_range(0, db + 2));
         step_sample(bdpc_pkg::LEVEL_PRESSED, db + $urandom_range(0, 2));
         // short holds up to just past the threshold, long ones at or beyond it
         hold = (kind < 6) ? $urandom_range(0, lp + 1) : lp + $urandom_range(0, lp/4 + 3);
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++)
            step_sample(bdpc_pkg::LEVEL_PRESSED,
                        (i == n - 1) ? hold - (n - 1) * (hold / n) : hold / n);
         bounce(bdpc_pkg::LEVEL_RELEASED, db);
         step_sample(bdpc_pkg::LEVEL_RELEASED, $urandom_range(0, db + 2));
         step_sample(bdpc_pkg::LEVEL_RELEASED, db + $urandom_range(0, 2));
      end
   endtask

   task automatic random_phase(logic [bdpc_pkg::CFG_W-1:0] debounce,
                               logic [bdpc_pkg::CFG_W-1:0] long_ms, int count);
      int target;
      set_timing(debounce, long_ms);
      target = sb.samples + count;
      while (sb.samples < target)
         press_episode();
   endtask

   initial begin
      sb                     = new();
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.raw_level       = bdpc_pkg::LEVEL_RELEASED;
      req_ch.now_ms          = '0;
      req_ch.display_awake   = 1'b0;
      req_ch.config_mode     = 1'b0;
      req_ch.charging_active = 1'b0;
      csr_ch.valid           = 1'b0;
      csr_ch.index           = bdpc_pkg::CSR_DEBOUNCE;
      csr_ch.data            = '0;
      req_burst              = 1'b0;
      settings               = 1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset timing: debounce boundary, long press boundary, no short after long
      drive_sample(bdpc_pkg::LEVEL_PRESSED,  100,  1'b1, 1'b0, 1'b0);
      drive_sample(bdpc_pkg::LEVEL_PRESSED,  150,  1'b1, 1'b0, 1'b0);
      drive_sample(bdpc_pkg::LEVEL_PRESSED,  151,  1'b1, 1'b0, 1'b0);
      drive_sample(bdpc_pkg::LEVEL_PRESSED,  2150, 1'b1, 1'b0, 1'b0);
      drive_sample(bdpc_pkg::LEVEL_PRESSED,  2151, 1'b1, 1'b0, 1'b0);
      drive_sample(bdpc_pkg::LEVEL_RELEASED, 2200, 1'b1, 1'b0, 1'b0);
      drive_sample(bdpc_pkg::LEVEL_RELEASED, 2251, 1'b1, 1'b0, 1'b0);
      // short press: awake, asleep, config mode, charging
      directed_tap(3000, 1'b1, 1'b0, 1'b0);
      directed_tap(4000, 1'b0, 1'b0, 1'b0);
      directed_tap(5000, 1'b1, 1'b1, 1'b0);
      directed_tap(6000, 1'b1, 1'b0, 1'b1);

      // Zero timing across the timestamp wrap: muted long press, then asleep
      set_timing('0, '0);
      drive_sample(bdpc_pkg::LEVEL_PRESSED,  32'hFFFF_FFFE, 1'b1, 1'b0, 1'b0);
      drive_sample(bdpc_pkg::LEVEL_PRESSED,  32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
      drive_sample(bdpc_pkg::LEVEL_RELEASED, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
      drive_sample(bdpc_pkg::LEVEL_RELEASED, 32'h0000_0001, 1'b1, 1'b0, 1'b0);
      drive_sample(bdpc_pkg::LEVEL_PRESSED,  32'h0000_0002, 1'b0, 1'b1, 1'b0);
      drive_sample(bdpc_pkg::LEVEL_PRESSED,  32'h0000_0003, 1'b0, 1'b1, 1'b0);
      sample_ms = 32'h0000_0003;

      // Random traffic under a range of timings
      random_phase('0, '0, 200);
      random_phase(16'hFFFF, 16'hFFFF, 200);
      random_phase(bdpc_pkg::DEBOUNCE_RST, bdpc_pkg::LONG_PRESS_RST, 250);
      random_phase(16'd3, 16'd20, 260);
      // a write to an undecoded index must change nothing
      wait_drained();
      program_csr(CSR_SPARE, 16'($urandom));
      csr_ch.valid <= 1'b0;
      random_phase(16'($urandom_range(0, 200)), 16'($urandom_range(0, 3000)), 260);
      random_phase(16'($urandom), 16'($urandom), 150);
      random_phase('0, 16'hFFFF, 75);
      random_phase(16'hFFFF, '0, 75);

      wait_drained();
      repeat (8) @(negedge clock);
      $display("Sent %0d samples under %0d timing settings; checked %0d results.",
               sb.samples, settings, sb.results);
      $display("Expected %0d short and %0d long presses; %0d mismatches.",
               sb.shorts, sb.longs, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_actions.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
